// ===== hdl/mpcp_pkg.sv =====
// Motor phase current protection: shared types, codes and widths.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mpcp_pkg;

  localparam int unsigned MUL_AW = 43;
  localparam int unsigned MUL_BW = 17;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned DIV_W  = 42;

  localparam logic [1:0] FUNC_SAMPLE     = 2'd0;
  localparam logic [1:0] FUNC_IDLE_KEEP  = 2'd1;
  localparam logic [1:0] FUNC_IDLE_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_RESERVED   = 2'd3;

  localparam logic [2:0] CFG_PLAUS_THR  = 3'd0;
  localparam logic [2:0] CFG_UNB_RATIO  = 3'd1;
  localparam logic [2:0] CFG_MIN_CURR   = 3'd2;
  localparam logic [2:0] CFG_SAVG_LIM   = 3'd3;
  localparam logic [2:0] CFG_LOSS_MAX   = 3'd4;
  localparam logic [2:0] CFG_OVL_THR    = 3'd5;
  localparam logic [2:0] CFG_LOCK_THR   = 3'd6;
  localparam logic [2:0] CFG_CMAX_THR   = 3'd7;

  localparam int unsigned AL_PLAUS = 0;
  localparam int unsigned AL_LOSS  = 1;
  localparam int unsigned AL_OVER  = 2;
  localparam int unsigned AL_LOCK  = 3;
  localparam int unsigned AL_CMAX  = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    J_SUM,
    J_MAG0,
    J_MAG1,
    J_MAG2,
    J_SGN0,
    J_SGN1,
    J_SGN2,
    J_UNB,
    J_SQU,
    J_SQD,
    J_I2
  } job_e;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic [MUL_BW-1:0]        b;
  } mul_req_t;

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    logic [16:0] r;
    r = v[16] ? 17'(-v) : 17'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mpcp_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, signed a by unsigned b.
// Depends on mpcp_pkg.
`default_nettype none
module mpcp_mul (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire mpcp_pkg::mul_req_t                   req_i,
  output logic                                      done_o,
  output logic signed [mpcp_pkg::MUL_PW-1:0]        prod_o
);

  localparam int unsigned CW = $clog2(mpcp_pkg::MUL_BW);

  logic                              busy_q;
  logic                              done_q;
  logic [CW-1:0]                     cnt_q;
  logic [mpcp_pkg::MUL_PW-1:0]       acc_q;
  logic [mpcp_pkg::MUL_PW-1:0]       a_q;
  logic [mpcp_pkg::MUL_BW-1:0]       b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(mpcp_pkg::MUL_BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= mpcp_pkg::MUL_PW'(req_i.a);
      b_q   <= req_i.b;
    end else if (busy_q) begin
      acc_q <= acc_q + (b_q[0] ? a_q : '0);
      a_q   <= {a_q[mpcp_pkg::MUL_PW-2:0], 1'b0};
      b_q   <= {1'b0, b_q[mpcp_pkg::MUL_BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = $signed(acc_q);

endmodule
`default_nettype wire

// ===== hdl/mpcp_div3.sv =====
// Restoring divider by three, one quotient bit per cycle.
// Depends on mpcp_pkg.
`default_nettype none
module mpcp_div3 (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [mpcp_pkg::DIV_W-1:0]     num_i,
  output logic                                done_o,
  output logic [mpcp_pkg::DIV_W-1:0]          quot_o
);

  localparam int unsigned CW = $clog2(mpcp_pkg::DIV_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CW-1:0]                 cnt_q;
  logic [mpcp_pkg::DIV_W-1:0]    n_q;
  logic [1:0]                    rem_q;
  logic [2:0]                    trial;
  logic                          ge;

  assign trial = {rem_q, n_q[mpcp_pkg::DIV_W-1]};
  assign ge    = trial >= 3'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(mpcp_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= 2'd0;
    end else if (busy_q) begin
      rem_q <= ge ? 2'(trial - 3'd3) : trial[1:0];
      n_q   <= {n_q[mpcp_pkg::DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule
`default_nettype wire

// ===== hdl/motor_phase_current_protection.sv =====
// Motor phase current protection top level: sequencer, filter state, alarms.
// Depends on mpcp_pkg, mpcp_mul and mpcp_div3.
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i / in_stall_o | func, phase u/v/w, raw u/v/w, duty_min
//   output  | out       | out_valid_o / out_stall_i | five alarms, filtered_i2
//   config  | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// An idle item goes from accept straight to output. A sample item is accepted,
// then runs ten passes of the serial multiplier, eleven when duty_min is above the
// floor (filters, unbalance product, two squares, I2 filter), with a serial divide
// by three before the I2 pass, then an output step; the multiplier sets the rate.
// Reset clears all filters, counters and alarms at once.
// A new item is taken while the last result still waits under out_stall_i.
`default_nettype none
module motor_phase_current_protection #(
  parameter int unsigned SUM_GAIN       = 3,
  parameter int unsigned PHASE_GAIN     = 6,
  parameter int unsigned I2_GAIN        = 193,
  parameter int unsigned OVERLOAD_TICKS = 1920000,
  parameter int unsigned LOCKED_TICKS   = 3200,
  parameter int unsigned DUTY_FLOOR     = 3277
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         func_i,
  input  wire logic signed [15:0] phase_u_i,
  input  wire logic signed [15:0] phase_v_i,
  input  wire logic signed [15:0] phase_w_i,
  input  wire logic signed [15:0] raw_phase_u_i,
  input  wire logic signed [15:0] raw_phase_v_i,
  input  wire logic signed [15:0] raw_phase_w_i,
  input  wire logic [15:0]        duty_min_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    alarm_plausibility_o,
  output logic                    alarm_phase_loss_o,
  output logic                    alarm_overload_o,
  output logic                    alarm_locked_rotor_o,
  output logic                    alarm_current_max_o,
  output logic [31:0]             filtered_i2_o
);

  localparam int unsigned AW = mpcp_pkg::MUL_AW;

  // configuration
  logic [17:0] plaus_thr_q;
  logic [15:0] unb_ratio_q;
  logic [14:0] min_curr_q;
  logic [14:0] savg_lim_q;
  logic [15:0] loss_max_q;
  logic [31:0] ovl_thr_q;
  logic [31:0] lock_thr_q;
  logic [31:0] cmax_thr_q;

  // control
  mpcp_pkg::state_e state_q, state_d;
  mpcp_pkg::job_e   job_q, job_d;
  logic             out_valid_q;
  logic             in_xfer;
  logic             out_load;

  // latched item
  logic signed [15:0] ph_q [3];
  logic signed [17:0] rsum_q;

  // filter and protection state
  logic signed [25:0] sum_q;
  logic [23:0]        mag_q [3];
  logic signed [23:0] sgn_q [3];
  logic [39:0]        i2_q;
  logic [15:0]        loss_cnt_q;
  logic [31:0]        ovl_ticks_q;
  logic [31:0]        lock_ticks_q;
  logic [4:0]         alarm_q;
  logic [31:0]        squ_q;
  logic [40:0]        xi2_q;

  // output register
  logic [4:0]  out_alarm_q;
  logic [31:0] out_i2_q;

  // datapath
  mpcp_pkg::mul_req_t              mul_req;
  logic                            mul_done;
  logic signed [mpcp_pkg::MUL_PW-1:0] mul_p;
  logic                            div_start;
  logic                            div_done;
  logic [mpcp_pkg::DIV_W-1:0]      div_q;
  logic signed [AW-1:0]            fx, fy, newv;
  logic [1:0]                      pidx;
  logic signed [mpcp_pkg::MUL_PW-1:0] prod_sh;
  logic [16:0]                     abs_ph [3];
  logic [16:0]                     abs_d;
  logic signed [16:0]              dvw;
  logic [25:0]                     sum_abs;
  logic [25:0]                     sabs;
  logic [43:0]                     lhs;
  logic [43:0]                     min_lim;
  logic [43:0]                     mag_lim [3];
  logic [23:0]                     sgn_abs [3];
  logic                            unb_bad;
  logic                            sgn_bad;
  logic                            bad;
  logic [39:0]                     i2_new;
  logic [31:0]                     ovl_inc, lock_inc;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_load = (state_q == mpcp_pkg::S_OUT) && (!out_valid_q || !out_stall_i);

  for (genvar k = 0; k < 3; k++) begin : g_ph
    assign abs_ph[k]  = mpcp_pkg::abs17({ph_q[k][15], ph_q[k]});
    assign sgn_abs[k] = sgn_q[k][23] ? 24'(-sgn_q[k]) : 24'(sgn_q[k]);
    assign mag_lim[k] = {2'b0, mag_q[k], 18'h0} - {4'b0, mag_q[k], 16'h0};
  end

  assign dvw     = {ph_q[1][15], ph_q[1]} - {ph_q[2][15], ph_q[2]};
  assign abs_d   = mpcp_pkg::abs17(dvw);
  assign sum_abs = {2'b0, mag_q[0]} + {2'b0, mag_q[1]} + {2'b0, mag_q[2]};

  always_comb begin
    pidx = 2'd0;
    unique case (job_q)
      mpcp_pkg::J_MAG1, mpcp_pkg::J_SGN1: pidx = 2'd1;
      mpcp_pkg::J_MAG2, mpcp_pkg::J_SGN2: pidx = 2'd2;
      default:                            pidx = 2'd0;
    endcase
  end

  always_comb begin
    fx        = '0;
    fy        = '0;
    mul_req.b = '0;
    unique case (job_q)
      mpcp_pkg::J_SUM: begin
        fx        = {{17{rsum_q[17]}}, rsum_q, 8'h0};
        fy        = {{17{sum_q[25]}}, sum_q};
        mul_req.b = 17'(SUM_GAIN);
      end
      mpcp_pkg::J_MAG0, mpcp_pkg::J_MAG1, mpcp_pkg::J_MAG2: begin
        fx        = {18'h0, abs_ph[pidx], 8'h0};
        fy        = {19'h0, mag_q[pidx]};
        mul_req.b = 17'(PHASE_GAIN);
      end
      mpcp_pkg::J_SGN0, mpcp_pkg::J_SGN1, mpcp_pkg::J_SGN2: begin
        fx        = {{19{ph_q[pidx][15]}}, ph_q[pidx], 8'h0};
        fy        = {{19{sgn_q[pidx][23]}}, sgn_q[pidx]};
        mul_req.b = 17'(PHASE_GAIN);
      end
      mpcp_pkg::J_UNB: begin
        fx        = {17'h0, sum_abs};
        mul_req.b = {1'b0, unb_ratio_q};
      end
      mpcp_pkg::J_SQU: begin
        fx        = {26'h0, abs_ph[0]};
        mul_req.b = abs_ph[0];
      end
      mpcp_pkg::J_SQD: begin
        fx        = {26'h0, abs_d};
        mul_req.b = abs_d;
      end
      mpcp_pkg::J_I2: begin
        fx        = {2'b0, xi2_q};
        fy        = {3'b0, i2_q};
        mul_req.b = 17'(I2_GAIN);
      end
      default: begin
        fx = '0;
      end
    endcase
    mul_req.a     = fx - fy;
    mul_req.start = (state_q == mpcp_pkg::S_MUL_GO);
  end

  mpcp_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  mpcp_div3 u_div3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({mul_p[33:0], 8'h0}),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign prod_sh = mul_p >>> 16;
  assign newv    = fy + $signed(prod_sh[AW-1:0]);
  assign sabs    = newv[25] ? 26'(-newv[25:0]) : newv[25:0];

  assign lhs     = mul_p[43:0];
  assign min_lim = {3'b0, min_curr_q, 26'h0} - {5'b0, min_curr_q, 24'h0};
  assign unb_bad = (min_lim < lhs) &&
                   ((mag_lim[0] < lhs) || (mag_lim[1] < lhs) || (mag_lim[2] < lhs));
  assign sgn_bad = (sgn_abs[0] > {1'b0, savg_lim_q, 8'h0}) ||
                   (sgn_abs[1] > {1'b0, savg_lim_q, 8'h0}) ||
                   (sgn_abs[2] > {1'b0, savg_lim_q, 8'h0});
  assign bad     = unb_bad || sgn_bad;

  assign i2_new   = newv[39:0];
  assign ovl_inc  = (ovl_ticks_q == '1) ? ovl_ticks_q : ovl_ticks_q + 32'd1;
  assign lock_inc = (lock_ticks_q == '1) ? lock_ticks_q : lock_ticks_q + 32'd1;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    div_start = 1'b0;
    unique case (state_q)
      mpcp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (func_i == mpcp_pkg::FUNC_SAMPLE) begin
            job_d   = (duty_min_i > 16'(DUTY_FLOOR)) ? mpcp_pkg::J_SUM : mpcp_pkg::J_MAG0;
            state_d = mpcp_pkg::S_MUL_GO;
          end else begin
            state_d = mpcp_pkg::S_OUT;
          end
        end
      end
      mpcp_pkg::S_MUL_GO: begin
        state_d = mpcp_pkg::S_MUL_WAIT;
      end
      mpcp_pkg::S_MUL_WAIT: begin
        if (mul_done) begin
          if (job_q == mpcp_pkg::J_SQD) begin
            div_start = 1'b1;
            state_d   = mpcp_pkg::S_DIV_WAIT;
          end else if (job_q == mpcp_pkg::J_I2) begin
            state_d = mpcp_pkg::S_OUT;
          end else begin
            job_d   = mpcp_pkg::job_e'(job_q + 4'd1);
            state_d = mpcp_pkg::S_MUL_GO;
          end
        end
      end
      mpcp_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          job_d   = mpcp_pkg::J_I2;
          state_d = mpcp_pkg::S_MUL_GO;
        end
      end
      mpcp_pkg::S_OUT: begin
        if (out_load) begin
          state_d = mpcp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mpcp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpcp_pkg::S_IDLE;
      job_q   <= mpcp_pkg::J_SUM;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plaus_thr_q <= 18'd4096;
      unb_ratio_q <= 16'd49152;
      min_curr_q  <= '0;
      savg_lim_q  <= 15'd1024;
      loss_max_q  <= '0;
      ovl_thr_q   <= '1;
      lock_thr_q  <= '1;
      cmax_thr_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mpcp_pkg::CFG_PLAUS_THR: plaus_thr_q <= cfg_data_i[17:0];
        mpcp_pkg::CFG_UNB_RATIO: unb_ratio_q <= cfg_data_i[15:0];
        mpcp_pkg::CFG_MIN_CURR:  min_curr_q  <= cfg_data_i[14:0];
        mpcp_pkg::CFG_SAVG_LIM:  savg_lim_q  <= cfg_data_i[14:0];
        mpcp_pkg::CFG_LOSS_MAX:  loss_max_q  <= cfg_data_i[15:0];
        mpcp_pkg::CFG_OVL_THR:   ovl_thr_q   <= cfg_data_i;
        mpcp_pkg::CFG_LOCK_THR:  lock_thr_q  <= cfg_data_i;
        mpcp_pkg::CFG_CMAX_THR:  cmax_thr_q  <= cfg_data_i;
        default:                 plaus_thr_q <= plaus_thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ph_q[0] <= phase_u_i;
      ph_q[1] <= phase_v_i;
      ph_q[2] <= phase_w_i;
      rsum_q  <= {{2{raw_phase_u_i[15]}}, raw_phase_u_i} +
                 {{2{raw_phase_v_i[15]}}, raw_phase_v_i} +
                 {{2{raw_phase_w_i[15]}}, raw_phase_w_i};
    end
    if (state_q == mpcp_pkg::S_MUL_WAIT && mul_done && job_q == mpcp_pkg::J_SQU) begin
      squ_q <= mul_p[31:0];
    end
    if (div_done) begin
      xi2_q <= {1'b0, squ_q, 8'h0} + div_q[40:0];
    end
    if (out_load) begin
      out_alarm_q <= alarm_q;
      out_i2_q    <= i2_q[39:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      mag_q[0]     <= '0;
      mag_q[1]     <= '0;
      mag_q[2]     <= '0;
      sgn_q[0]     <= '0;
      sgn_q[1]     <= '0;
      sgn_q[2]     <= '0;
      i2_q         <= '0;
      loss_cnt_q   <= '0;
      ovl_ticks_q  <= '0;
      lock_ticks_q <= '0;
      alarm_q      <= '0;
    end else if (in_xfer && func_i != mpcp_pkg::FUNC_SAMPLE) begin
      if (func_i == mpcp_pkg::FUNC_IDLE_KEEP || func_i == mpcp_pkg::FUNC_IDLE_CLEAR) begin
        loss_cnt_q   <= '0;
        ovl_ticks_q  <= '0;
        lock_ticks_q <= '0;
      end
      if (func_i == mpcp_pkg::FUNC_IDLE_CLEAR) begin
        alarm_q <= '0;
      end
    end else if (state_q == mpcp_pkg::S_MUL_WAIT && mul_done) begin
      case (job_q)
        mpcp_pkg::J_SUM: begin
          sum_q <= newv[25:0];
          if (sabs > {plaus_thr_q, 8'h0}) begin
            alarm_q[mpcp_pkg::AL_PLAUS] <= 1'b1;
          end
        end
        mpcp_pkg::J_MAG0, mpcp_pkg::J_MAG1, mpcp_pkg::J_MAG2: begin
          mag_q[pidx] <= newv[23:0];
        end
        mpcp_pkg::J_SGN0, mpcp_pkg::J_SGN1, mpcp_pkg::J_SGN2: begin
          sgn_q[pidx] <= newv[23:0];
        end
        mpcp_pkg::J_UNB: begin
          if (bad) begin
            if (loss_cnt_q < loss_max_q) begin
              loss_cnt_q <= loss_cnt_q + 16'd1;
            end else begin
              alarm_q[mpcp_pkg::AL_LOSS] <= 1'b1;
            end
          end else if (loss_cnt_q != '0) begin
            loss_cnt_q <= loss_cnt_q - 16'd1;
          end
        end
        mpcp_pkg::J_I2: begin
          i2_q <= i2_new;
          if (i2_new > {ovl_thr_q, 8'h0}) begin
            ovl_ticks_q <= ovl_inc;
            if (ovl_inc >= 32'(OVERLOAD_TICKS)) begin
              alarm_q[mpcp_pkg::AL_OVER] <= 1'b1;
            end
          end else begin
            ovl_ticks_q <= '0;
          end
          if (i2_new > {lock_thr_q, 8'h0}) begin
            lock_ticks_q <= lock_inc;
            if (lock_inc >= 32'(LOCKED_TICKS)) begin
              alarm_q[mpcp_pkg::AL_LOCK] <= 1'b1;
            end
          end else begin
            lock_ticks_q <= '0;
          end
          if (i2_new > {cmax_thr_q, 8'h0}) begin
            alarm_q[mpcp_pkg::AL_CMAX] <= 1'b1;
          end
        end
        default: begin
          alarm_q <= alarm_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o           = (state_q != mpcp_pkg::S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign alarm_plausibility_o = out_alarm_q[mpcp_pkg::AL_PLAUS];
  assign alarm_phase_loss_o   = out_alarm_q[mpcp_pkg::AL_LOSS];
  assign alarm_overload_o     = out_alarm_q[mpcp_pkg::AL_OVER];
  assign alarm_locked_rotor_o = out_alarm_q[mpcp_pkg::AL_LOCK];
  assign alarm_current_max_o  = out_alarm_q[mpcp_pkg::AL_CMAX];
  assign filtered_i2_o        = out_i2_q;

  a_mul_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == mpcp_pkg::S_MUL_WAIT))
    else $error("multiplier finished outside its wait state");

  a_alarms_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_xfer && func_i == mpcp_pkg::FUNC_IDLE_CLEAR)
    |=> ((alarm_q & $past(alarm_q)) == $past(alarm_q)))
    else $error("alarm dropped without a clearing idle transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpcp_pkg::S_OUT && out_valid_o && out_stall_i)
    |=> (state_q == mpcp_pkg::S_OUT))
    else $error("result overwrote a stalled transfer");

endmodule
`default_nettype wire

// ===== tb/mpcp_checker.sv =====
// Checker for motor_phase_current_protection: watches the input, output and
// configuration ports, predicts each result and compares it. Depends on mpcp_pkg.
`timescale 1ns / 1ps
module mpcp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [15:0] phase_u_i,
  input  logic signed [15:0] phase_v_i,
  input  logic signed [15:0] phase_w_i,
  input  logic signed [15:0] raw_phase_u_i,
  input  logic signed [15:0] raw_phase_v_i,
  input  logic signed [15:0] raw_phase_w_i,
  input  logic [15:0]        duty_min_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [4:0]         alarms_o,
  input  logic [31:0]        filtered_i2_o,
  output int                 fail_count,
  output int                 pending
);

  localparam longint SUM_GAIN = 3;
  localparam longint PHASE_GAIN = 6;
  localparam longint I2_GAIN = 193;
  localparam longint OVERLOAD_TICKS = 1920000;
  localparam longint LOCKED_TICKS = 3200;
  localparam longint DUTY_FLOOR = 3277;

  typedef struct packed {
    logic [4:0]  alarms;
    logic [31:0] i2;
  } status_t;

  status_t status_q[$];

  logic [17:0] plaus_thr;
  logic [15:0] unb_ratio;
  logic [14:0] min_curr;
  logic [14:0] savg_lim;
  logic [15:0] loss_max;
  logic [31:0] ovl_thr, lock_thr, cmax_thr;

  longint sum_lp, i2_lp;
  longint mag_lp[3], sgn_lp[3];
  logic [15:0] loss_cnt;
  logic [31:0] ovl_ticks, lock_ticks;
  logic [4:0] alarm_exp;

  function automatic longint fdiv16(longint v);
    if (v >= 0) return v >>> 16;
    return -(((-v) - 1) >>> 16) - 1;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] tick_up(logic [31:0] t);
    return (t == 32'hFFFF_FFFF) ? t : t + 32'd1;
  endfunction

  task automatic predict_status();
    longint ph[3];
    longint raw_sum, sum_abs, lhs, d, i2_in, ip;
    bit bad;
    status_t s;
    bad = 0;
    if (func_i == mpcp_pkg::FUNC_SAMPLE) begin
      ph[0] = phase_u_i; ph[1] = phase_v_i; ph[2] = phase_w_i;
      raw_sum = longint'(raw_phase_u_i) + raw_phase_v_i + raw_phase_w_i;
      if (longint'(duty_min_i) > DUTY_FLOOR) begin
        sum_lp += fdiv16((raw_sum * 256 - sum_lp) * SUM_GAIN);
        if (labs(sum_lp) > longint'(plaus_thr) * 256) alarm_exp[mpcp_pkg::AL_PLAUS] = 1'b1;
      end
      for (int k = 0; k < 3; k++) begin
        mag_lp[k] += fdiv16((labs(ph[k]) * 256 - mag_lp[k]) * PHASE_GAIN);
        sgn_lp[k] += fdiv16((ph[k] * 256 - sgn_lp[k]) * PHASE_GAIN);
      end
      sum_abs = mag_lp[0] + mag_lp[1] + mag_lp[2];
      lhs = longint'(unb_ratio) * sum_abs;
      if (longint'(min_curr) * 256 * 196608 < lhs)
        for (int k = 0; k < 3; k++) if (mag_lp[k] * 196608 < lhs) bad = 1;
      for (int k = 0; k < 3; k++)
        if (labs(sgn_lp[k]) > longint'(savg_lim) * 256) bad = 1;
      if (bad) begin
        if (loss_cnt < loss_max) loss_cnt++;
        else alarm_exp[mpcp_pkg::AL_LOSS] = 1'b1;
      end else if (loss_cnt > 0) begin
        loss_cnt--;
      end
      d = ph[1] - ph[2];
      i2_in = ph[0] * ph[0] * 256 + (d * d * 256) / 3;
      i2_lp += fdiv16((i2_in - i2_lp) * I2_GAIN);
      if (i2_lp > longint'(ovl_thr) * 256) begin
        ovl_ticks = tick_up(ovl_ticks);
        if (longint'(ovl_ticks) >= OVERLOAD_TICKS) alarm_exp[mpcp_pkg::AL_OVER] = 1'b1;
      end else ovl_ticks = '0;
      if (i2_lp > longint'(lock_thr) * 256) begin
        lock_ticks = tick_up(lock_ticks);
        if (longint'(lock_ticks) >= LOCKED_TICKS) alarm_exp[mpcp_pkg::AL_LOCK] = 1'b1;
      end else lock_ticks = '0;
      if (i2_lp > longint'(cmax_thr) * 256) alarm_exp[mpcp_pkg::AL_CMAX] = 1'b1;
    end else if (func_i == mpcp_pkg::FUNC_IDLE_KEEP ||
                 func_i == mpcp_pkg::FUNC_IDLE_CLEAR) begin
      loss_cnt = '0;
      ovl_ticks = '0;
      lock_ticks = '0;
      if (func_i == mpcp_pkg::FUNC_IDLE_CLEAR) alarm_exp = '0;
    end
    ip = i2_lp < 0 ? 0 : i2_lp / 256;
    s.alarms = alarm_exp;
    s.i2 = ip > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(ip);
    status_q.push_back(s);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    status_t e;
    if (!rst_ni) begin
      plaus_thr = 18'd4096; unb_ratio = 16'd49152; min_curr = '0; savg_lim = 15'd1024;
      loss_max = '0; ovl_thr = '1; lock_thr = '1; cmax_thr = '1;
      sum_lp = 0; i2_lp = 0;
      for (int k = 0; k < 3; k++) begin
        mag_lp[k] = 0; sgn_lp[k] = 0;
      end
      loss_cnt = '0; ovl_ticks = '0; lock_ticks = '0; alarm_exp = '0;
      status_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mpcp_pkg::CFG_PLAUS_THR: plaus_thr = cfg_data_i[17:0];
          mpcp_pkg::CFG_UNB_RATIO: unb_ratio = cfg_data_i[15:0];
          mpcp_pkg::CFG_MIN_CURR:  min_curr = cfg_data_i[14:0];
          mpcp_pkg::CFG_SAVG_LIM:  savg_lim = cfg_data_i[14:0];
          mpcp_pkg::CFG_LOSS_MAX:  loss_max = cfg_data_i[15:0];
          mpcp_pkg::CFG_OVL_THR:   ovl_thr = cfg_data_i;
          mpcp_pkg::CFG_LOCK_THR:  lock_thr = cfg_data_i;
          mpcp_pkg::CFG_CMAX_THR:  cmax_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected transfer: alarms %b i2 %0d",
                                         alarms_o, filtered_i2_o);
        end else begin
          e = status_q.pop_front();
          if (e.alarms !== alarms_o || e.i2 !== filtered_i2_o) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: alarms exp %b got %b, i2 exp %0d got %0d",
                       e.alarms, alarms_o, e.i2, filtered_i2_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) predict_status();
      pending = status_q.size();
    end
  end

endmodule

// ===== tb/motor_phase_current_protection_test.sv =====
// Testbench top for motor_phase_current_protection: drives samples, idle items
// and register writes with random gaps. Depends on mpcp_pkg, mpcp_checker and motor_phase_current_protection.
`timescale 1ns / 1ps
module motor_phase_current_protection_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic signed [15:0] phase_u_i = '0, phase_v_i = '0, phase_w_i = '0;
  logic signed [15:0] raw_phase_u_i = '0, raw_phase_v_i = '0, raw_phase_w_i = '0;
  logic [15:0] duty_min_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [4:0] alarms;
  logic [31:0] filtered_i2_o;
  int fail_count, pending;
  int cycle_count = 0;
  bit hold_off = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  motor_phase_current_protection dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .phase_u_i, .phase_v_i, .phase_w_i,
    .raw_phase_u_i, .raw_phase_v_i, .raw_phase_w_i, .duty_min_i,
    .out_valid_o, .out_stall_i,
    .alarm_plausibility_o(alarms[mpcp_pkg::AL_PLAUS]),
    .alarm_phase_loss_o(alarms[mpcp_pkg::AL_LOSS]),
    .alarm_overload_o(alarms[mpcp_pkg::AL_OVER]),
    .alarm_locked_rotor_o(alarms[mpcp_pkg::AL_LOCK]),
    .alarm_current_max_o(alarms[mpcp_pkg::AL_CMAX]), .filtered_i2_o
  );

  mpcp_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .phase_u_i, .phase_v_i, .phase_w_i,
    .raw_phase_u_i, .raw_phase_v_i, .raw_phase_w_i, .duty_min_i,
    .out_valid_o, .out_stall_i, .alarms_o(alarms), .filtered_i2_o,
    .fail_count, .pending
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Receiver stall: random, with stall-free windows early in the run, plus a forced hold-off.
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else if (cycle_count < 200000 && cycle_count % 50000 > 40000) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] f, logic signed [15:0] u, v, w, ru, rv, rw,
                           logic [15:0] duty);
    func_i <= f; phase_u_i <= u; phase_v_i <= v; phase_w_i <= w;
    raw_phase_u_i <= ru; raw_phase_v_i <= rv; raw_phase_w_i <= rw;
    duty_min_i <= duty; in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_sample(int mode);
    logic signed [15:0] u, v, w;
    int a;
    a = (mode == 0) ? 32767 : (mode == 1 ? 3000 : 200);
    u = 16'($urandom_range(0, 2 * a) - a);
    v = 16'($urandom_range(0, 2 * a) - a);
    w = 16'($urandom_range(0, 2 * a) - a);
    if ($urandom_range(0, 9) == 0) v = '0;
    if (mode == 0) begin
      u = 16'($urandom); v = 16'($urandom); w = 16'($urandom);
    end
    send_item(mpcp_pkg::FUNC_SAMPLE, u, v, w,
              (mode == 0) ? 16'($urandom) : 16'(u + $urandom_range(0, 400) - 200),
              (mode == 0) ? 16'($urandom) : v, (mode == 0) ? 16'($urandom) : w,
              16'($urandom));
  endtask

  initial begin
    logic [1:0] f;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_item(mpcp_pkg::FUNC_SAMPLE, 16'sh7FFF, -16'sd32768, 16'sh7FFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    send_item(mpcp_pkg::FUNC_SAMPLE, -16'sd32768, 16'sh7FFF, -16'sd32768,
              -16'sd32768, -16'sd32768, -16'sd32768, 16'd3278);
    send_item(mpcp_pkg::FUNC_SAMPLE, '0, '0, '0, 16'sh7FFF, 16'sh7FFF, '0, 16'd3277);
    send_item(mpcp_pkg::FUNC_SAMPLE, 16'sd1000, 16'sd1000, '0, '0, '0, '0, 16'd0);
    send_item(mpcp_pkg::FUNC_IDLE_KEEP, '0, '0, '0, '0, '0, '0, '0);
    send_item(mpcp_pkg::FUNC_RESERVED, '1, '1, '1, '1, '1, '1, 16'hFFFF);
    send_item(mpcp_pkg::FUNC_IDLE_CLEAR, '0, '0, '0, '0, '0, '0, '0);
    drain();
    write_reg(mpcp_pkg::CFG_PLAUS_THR, 32'd0);
    write_reg(mpcp_pkg::CFG_UNB_RATIO, 32'hFFFF);
    write_reg(mpcp_pkg::CFG_MIN_CURR, 32'd0);
    write_reg(mpcp_pkg::CFG_SAVG_LIM, 32'd0);
    write_reg(mpcp_pkg::CFG_LOSS_MAX, 32'd2);
    write_reg(mpcp_pkg::CFG_OVL_THR, 32'd0);
    write_reg(mpcp_pkg::CFG_LOCK_THR, 32'd0);
    write_reg(mpcp_pkg::CFG_CMAX_THR, 32'd1000000);
    for (int i = 0; i < 10; i++) send_item(mpcp_pkg::FUNC_SAMPLE, 16'sd20000, -16'sd3,
                                           16'sd5, 16'sd9, 16'sd9, 16'sd9, 16'd60000);
    send_item(mpcp_pkg::FUNC_IDLE_KEEP, '0, '0, '0, '0, '0, '0, '0);
    send_item(mpcp_pkg::FUNC_IDLE_CLEAR, '0, '0, '0, '0, '0, '0, '0);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(mpcp_pkg::CFG_PLAUS_THR, 32'd262143);
          write_reg(mpcp_pkg::CFG_UNB_RATIO, 32'd0);
          write_reg(mpcp_pkg::CFG_MIN_CURR, 32'd32767);
          write_reg(mpcp_pkg::CFG_SAVG_LIM, 32'd32767);
          write_reg(mpcp_pkg::CFG_LOSS_MAX, 32'd65535);
          write_reg(mpcp_pkg::CFG_OVL_THR, 32'hFFFF_FFFF);
          write_reg(mpcp_pkg::CFG_LOCK_THR, 32'hFFFF_FFFF);
          write_reg(mpcp_pkg::CFG_CMAX_THR, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(mpcp_pkg::CFG_PLAUS_THR, 32'd300);
          write_reg(mpcp_pkg::CFG_UNB_RATIO, 32'd49152);
          write_reg(mpcp_pkg::CFG_MIN_CURR, 32'd100);
          write_reg(mpcp_pkg::CFG_SAVG_LIM, 32'd500);
          write_reg(mpcp_pkg::CFG_LOSS_MAX, 32'd5);
          write_reg(mpcp_pkg::CFG_OVL_THR, 32'd2000000);
          write_reg(mpcp_pkg::CFG_LOCK_THR, 32'd3000000);
          write_reg(mpcp_pkg::CFG_CMAX_THR, 32'd9000000);
        end
        2: begin
          write_reg(mpcp_pkg::CFG_LOSS_MAX, 32'd1);
          write_reg(mpcp_pkg::CFG_LOCK_THR, 32'd10000);
          write_reg(mpcp_pkg::CFG_CMAX_THR, 32'd50000000);
        end
        3: begin
          write_reg(mpcp_pkg::CFG_PLAUS_THR, $urandom_range(0, 262143));
          write_reg(mpcp_pkg::CFG_UNB_RATIO, $urandom_range(30000, 65535));
          write_reg(mpcp_pkg::CFG_MIN_CURR, $urandom_range(0, 2000));
          write_reg(mpcp_pkg::CFG_SAVG_LIM, $urandom_range(0, 4000));
          write_reg(mpcp_pkg::CFG_LOSS_MAX, $urandom_range(0, 20));
          write_reg(mpcp_pkg::CFG_OVL_THR, $urandom_range(0, 20000000));
          write_reg(mpcp_pkg::CFG_LOCK_THR, $urandom_range(0, 20000000));
          write_reg(mpcp_pkg::CFG_CMAX_THR, $urandom);
        end
        default: write_reg(mpcp_pkg::CFG_LOSS_MAX, 32'd0);
      endcase
      for (int i = 0; i < 320; i++) begin
        f = ($urandom_range(0, 29) == 0) ? 2'($urandom_range(1, 3)) : mpcp_pkg::FUNC_SAMPLE;
        if (ph == 2 && i == 100) begin
          hold_off = 1;
          fork
            begin
              repeat (3000) @(negedge clk_i);
              hold_off = 0;
            end
          join_none
        end
        if (ph == 1 && i == 160) drain();
        if (f == mpcp_pkg::FUNC_SAMPLE) random_sample($urandom_range(0, 2));
        else send_item(f, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
        pause_sender();
      end
      drain();
    end
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
